// ===== rtl/core/nrpc_pkg.sv =====
package nrpc_pkg;

	localparam int unsigned CHAN_W   = 8;
	localparam int unsigned SQ_W     = 2 * CHAN_W;
	localparam int unsigned DIST_W   = 18;
	localparam int unsigned IDX_W    = 4;
	localparam int unsigned PAL_SIZE = 16;
	localparam int unsigned N_LEVELS = 4;
	localparam int unsigned N_CHAN   = 3;
	localparam int unsigned MAX_DIST = 195075;

	localparam int unsigned CH_RED   = 0;
	localparam int unsigned CH_GREEN = 1;
	localparam int unsigned CH_BLUE  = 2;

	typedef logic [1:0] level_code_t;

	localparam level_code_t LV_0   = 2'd0;
	localparam level_code_t LV_85  = 2'd1;
	localparam level_code_t LV_170 = 2'd2;
	localparam level_code_t LV_255 = 2'd3;

	typedef logic [N_LEVELS-1:0][CHAN_W-1:0] level_vec_t;

	localparam level_vec_t LEVEL_VALUE = {8'd255, 8'd170, 8'd85, 8'd0};

	typedef struct packed {
		level_code_t r;
		level_code_t g;
		level_code_t b;
	} pal_entry_t;

	typedef pal_entry_t [PAL_SIZE-1:0] pal_table_t;

	localparam pal_table_t PALETTE = {
		pal_entry_t'{LV_255, LV_255, LV_255},
		pal_entry_t'{LV_255, LV_255, LV_85},
		pal_entry_t'{LV_255, LV_85,  LV_255},
		pal_entry_t'{LV_255, LV_85,  LV_85},
		pal_entry_t'{LV_85,  LV_255, LV_255},
		pal_entry_t'{LV_85,  LV_255, LV_85},
		pal_entry_t'{LV_85,  LV_85,  LV_255},
		pal_entry_t'{LV_85,  LV_85,  LV_85},
		pal_entry_t'{LV_170, LV_170, LV_170},
		pal_entry_t'{LV_170, LV_85,  LV_0},
		pal_entry_t'{LV_170, LV_0,   LV_170},
		pal_entry_t'{LV_170, LV_0,   LV_0},
		pal_entry_t'{LV_0,   LV_170, LV_170},
		pal_entry_t'{LV_0,   LV_170, LV_0},
		pal_entry_t'{LV_0,   LV_0,   LV_170},
		pal_entry_t'{LV_0,   LV_0,   LV_0}
	};

	typedef logic [PAL_SIZE-1:0][DIST_W-1:0] dist_vec_t;

	typedef struct packed {
		logic [IDX_W-1:0]  idx;
		logic [DIST_W-1:0] dist_sq;
	} cand_t;

	// The first argument must carry the lower index, so ties keep it.
	function automatic cand_t pick_nearer(input cand_t lo, input cand_t hi);
		cand_t res;
		res = (hi.dist_sq < lo.dist_sq) ? hi : lo;
		return res;
	endfunction

endpackage

// ===== rtl/core/nrpc_if.sv =====
interface nrpc_pixel_if;
	logic                        valid;
	logic                        ready;
	logic [nrpc_pkg::CHAN_W-1:0] red;
	logic [nrpc_pkg::CHAN_W-1:0] green;
	logic [nrpc_pkg::CHAN_W-1:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);
endinterface

interface nrpc_dist_if;
	logic                valid;
	logic                ready;
	nrpc_pkg::dist_vec_t dist_sq;

	modport source (output valid, output dist_sq, input ready);
	modport sink (input valid, input dist_sq, output ready);
endinterface

interface nrpc_result_if;
	logic                        valid;
	logic                        ready;
	logic [nrpc_pkg::IDX_W-1:0]  palette_index;
	logic [nrpc_pkg::DIST_W-1:0] min_dist_sq;

	modport source (output valid, output palette_index, output min_dist_sq, input ready);
	modport sink (input valid, input palette_index, input min_dist_sq, output ready);
endinterface

// ===== rtl/core/nrpc_dist.sv =====
module nrpc_dist (
	input  logic         clk,
	input  logic         arst_n,
	nrpc_pixel_if.sink   pixel,
	nrpc_dist_if.source  dist_out
);

	typedef logic [nrpc_pkg::N_CHAN-1:0][nrpc_pkg::N_LEVELS-1:0][nrpc_pkg::CHAN_W-1:0] diff_t;
	typedef logic [nrpc_pkg::N_CHAN-1:0][nrpc_pkg::N_LEVELS-1:0][nrpc_pkg::SQ_W-1:0] sq_t;

	logic valid_s1, valid_s2, valid_s3;
	logic rdy_s1, rdy_s2, rdy_s3;

	diff_t               diff_c, diff_s1;
	sq_t                 sq_c, sq_s2;
	nrpc_pkg::dist_vec_t dist_c, dist_s3;

	assign rdy_s3      = !valid_s3 || dist_out.ready;
	assign rdy_s2      = !valid_s2 || rdy_s3;
	assign rdy_s1      = !valid_s1 || rdy_s2;
	assign pixel.ready = rdy_s1;

	always_comb begin
		logic [nrpc_pkg::N_CHAN-1:0][nrpc_pkg::CHAN_W-1:0] chan;
		chan[nrpc_pkg::CH_RED]   = pixel.red;
		chan[nrpc_pkg::CH_GREEN] = pixel.green;
		chan[nrpc_pkg::CH_BLUE]  = pixel.blue;
		for (int c = 0; c < nrpc_pkg::N_CHAN; c++) begin
			for (int l = 0; l < nrpc_pkg::N_LEVELS; l++) begin
				diff_c[c][l] = (chan[c] >= nrpc_pkg::LEVEL_VALUE[l]) ?
					chan[c] - nrpc_pkg::LEVEL_VALUE[l] :
					nrpc_pkg::LEVEL_VALUE[l] - chan[c];
			end
		end
	end

	always_comb begin
		for (int c = 0; c < nrpc_pkg::N_CHAN; c++) begin
			for (int l = 0; l < nrpc_pkg::N_LEVELS; l++) begin
				sq_c[c][l] = nrpc_pkg::SQ_W'(diff_s1[c][l]) * nrpc_pkg::SQ_W'(diff_s1[c][l]);
			end
		end
	end

	always_comb begin
		for (int k = 0; k < nrpc_pkg::PAL_SIZE; k++) begin
			dist_c[k] =
				nrpc_pkg::DIST_W'(sq_s2[nrpc_pkg::CH_RED][nrpc_pkg::PALETTE[k].r]) +
				nrpc_pkg::DIST_W'(sq_s2[nrpc_pkg::CH_GREEN][nrpc_pkg::PALETTE[k].g]) +
				nrpc_pkg::DIST_W'(sq_s2[nrpc_pkg::CH_BLUE][nrpc_pkg::PALETTE[k].b]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (rdy_s1) valid_s1 <= pixel.valid;
			if (rdy_s2) valid_s2 <= valid_s1;
			if (rdy_s3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && pixel.valid) diff_s1 <= diff_c;
		if (rdy_s2 && valid_s1) sq_s2 <= sq_c;
		if (rdy_s3 && valid_s2) dist_s3 <= dist_c;
	end

	assign dist_out.valid   = valid_s3;
	assign dist_out.dist_sq = dist_s3;

endmodule

// ===== rtl/core/nrpc_argmin.sv =====
module nrpc_argmin (
	input  logic           clk,
	input  logic           arst_n,
	nrpc_dist_if.sink      dist_in,
	nrpc_result_if.source  result
);

	localparam int unsigned N_MID = nrpc_pkg::PAL_SIZE / 4;

	logic valid_s4, valid_s5;
	logic rdy_s4, rdy_s5;

	nrpc_pkg::cand_t [N_MID-1:0] mid_c, mid_s4;
	nrpc_pkg::cand_t             best_c, best_s5;

	assign rdy_s5        = !valid_s5 || result.ready;
	assign rdy_s4        = !valid_s4 || rdy_s5;
	assign dist_in.ready = rdy_s4;

	always_comb begin
		nrpc_pkg::cand_t [nrpc_pkg::PAL_SIZE-1:0] leaf;
		nrpc_pkg::cand_t [2*N_MID-1:0]            pair;
		for (int k = 0; k < nrpc_pkg::PAL_SIZE; k++) begin
			leaf[k].idx     = nrpc_pkg::IDX_W'(k);
			leaf[k].dist_sq = dist_in.dist_sq[k];
		end
		for (int p = 0; p < 2 * N_MID; p++) begin
			pair[p] = nrpc_pkg::pick_nearer(leaf[2*p], leaf[2*p+1]);
		end
		for (int m = 0; m < N_MID; m++) begin
			mid_c[m] = nrpc_pkg::pick_nearer(pair[2*m], pair[2*m+1]);
		end
	end

	always_comb begin
		nrpc_pkg::cand_t lo_half, hi_half;
		lo_half = nrpc_pkg::pick_nearer(mid_s4[0], mid_s4[1]);
		hi_half = nrpc_pkg::pick_nearer(mid_s4[2], mid_s4[3]);
		best_c  = nrpc_pkg::pick_nearer(lo_half, hi_half);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (rdy_s4) valid_s4 <= dist_in.valid;
			if (rdy_s5) valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && dist_in.valid) mid_s4 <= mid_c;
		if (rdy_s5 && valid_s4) best_s5 <= best_c;
	end

	assign result.valid         = valid_s5;
	assign result.palette_index = best_s5.idx;
	assign result.min_dist_sq   = best_s5.dist_sq;

endmodule

// ===== rtl/core/nearest_palette_color_core.sv =====
// Maps each 24-bit RGB pixel to the nearest of 16 fixed CGA colors (channel levels 0, 85,
// 170 and 255) and returns that color's index with the squared distance to it; ties go to
// the lower index. A pixel is taken every clock unless back-pressure fills the pipeline:
// three stages form the channel differences, their squares and the sixteen distance sums,
// and two stages reduce them through a compare tree. Each stage
// holds its data while the stage after it is full and stalled, so the pipeline keeps
// filling its empty stages while a result waits on the output.
module nearest_palette_color_core (
	input  logic           clk,
	input  logic           arst_n,
	nrpc_pixel_if.sink     pixel,
	nrpc_result_if.source  result
);

	localparam int unsigned DEPTH = 5;

	nrpc_dist_if dist_ch ();

	logic [2:0] inflight_q;

	nrpc_dist u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.pixel    (pixel),
		.dist_out (dist_ch)
	);

	nrpc_argmin u_argmin (
		.clk     (clk),
		.arst_n  (arst_n),
		.dist_in (dist_ch),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + 3'(pixel.valid && pixel.ready)
				- 3'(result.valid && result.ready);
		end
	end

	a_dist_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> 32'(result.min_dist_sq) <= nrpc_pkg::MAX_DIST)
		else $error("result distance out of range");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		32'(inflight_q) <= DEPTH)
		else $error("more beats in flight than pipeline stages");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> inflight_q != 3'd0)
		else $error("result beat without an accepted pixel");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		32'(inflight_q) == DEPTH && !result.ready |-> !pixel.ready)
		else $error("pixel accepted into a full pipeline");

endmodule

// ===== dv/tb_nearest_palette_color_core.sv =====
`timescale 1ns / 1ps

module tb_nearest_palette_color_core;

	localparam int unsigned CYCLE_LIMIT = 200000;

	localparam logic [0:15][23:0] PAL_RGB = {
		24'h000000, 24'h0000AA, 24'h00AA00, 24'h00AAAA,
		24'hAA0000, 24'hAA00AA, 24'hAA5500, 24'hAAAAAA,
		24'h555555, 24'h5555FF, 24'h55FF55, 24'h55FFFF,
		24'hFF5555, 24'hFF55FF, 24'hFFFF55, 24'hFFFFFF
	};

	localparam logic [0:9][nrpc_pkg::CHAN_W-1:0] EDGE_LEVELS = {
		8'd0, 8'd42, 8'd43, 8'd85, 8'd127, 8'd128, 8'd170, 8'd212, 8'd213, 8'd255
	};

	typedef struct {
		logic [nrpc_pkg::IDX_W-1:0]  idx;
		logic [nrpc_pkg::DIST_W-1:0] dist_sq;
	} nearest_t;

	logic clk;
	logic arst_n;

	nrpc_pixel_if  pixel_bus ();
	nrpc_result_if result_bus ();

	nearest_palette_color_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pixel  (pixel_bus),
		.result (result_bus)
	);

	nearest_t    pending_colors[$];
	int unsigned error_count;
	int unsigned pixels_sent;
	int unsigned results_checked;
	int unsigned cycle_count;
	bit          idle_on;
	int unsigned hold_left;

	function automatic logic [nrpc_pkg::DIST_W-1:0] chan_dist_sq(
			input logic [nrpc_pkg::CHAN_W-1:0] a, input logic [nrpc_pkg::CHAN_W-1:0] b);
		logic [nrpc_pkg::CHAN_W-1:0] diff;
		diff = (a >= b) ? (a - b) : (b - a);
		return nrpc_pkg::DIST_W'(diff) * nrpc_pkg::DIST_W'(diff);
	endfunction

	function automatic nearest_t nearest_color(input logic [nrpc_pkg::CHAN_W-1:0] r,
			input logic [nrpc_pkg::CHAN_W-1:0] g, input logic [nrpc_pkg::CHAN_W-1:0] b);
		nearest_t                    best;
		logic [nrpc_pkg::DIST_W-1:0] d;
		best.idx     = '0;
		best.dist_sq = '1;
		for (int k = 0; k < nrpc_pkg::PAL_SIZE; k++) begin
			d = chan_dist_sq(r, PAL_RGB[k][23:16]) + chan_dist_sq(g, PAL_RGB[k][15:8])
				+ chan_dist_sq(b, PAL_RGB[k][7:0]);
			if (d < best.dist_sq) begin
				best.dist_sq = d;
				best.idx     = nrpc_pkg::IDX_W'(k);
			end
		end
		return best;
	endfunction

	task automatic report_mismatch(input string what);
		error_count++;
		$display("[%0t] mismatch: %s", $time, what);
	endtask

	task automatic send_pixel(input logic [nrpc_pkg::CHAN_W-1:0] r,
			input logic [nrpc_pkg::CHAN_W-1:0] g, input logic [nrpc_pkg::CHAN_W-1:0] b);
		int unsigned gap;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 6);
			pixel_bus.valid <= 1'b0;
			pixel_bus.red   <= nrpc_pkg::CHAN_W'($urandom);
			pixel_bus.green <= nrpc_pkg::CHAN_W'($urandom);
			pixel_bus.blue  <= nrpc_pkg::CHAN_W'($urandom);
			repeat (gap) @(posedge clk);
		end
		pixel_bus.valid <= 1'b1;
		pixel_bus.red   <= r;
		pixel_bus.green <= g;
		pixel_bus.blue  <= b;
		@(posedge clk);
		while (pixel_bus.ready !== 1'b1) @(posedge clk);
		pending_colors.push_back(nearest_color(r, g, b));
		pixels_sent++;
	endtask

	task automatic test_corners();
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd255);
		for (int k = 0; k < nrpc_pkg::PAL_SIZE; k++) begin
			send_pixel(PAL_RGB[k][23:16], PAL_RGB[k][15:8], PAL_RGB[k][7:0]);
		end
		// The first two points sit exactly between two entries and must go to the lower index.
		send_pixel(8'd0, 8'd0, 8'd85);
		send_pixel(8'd0, 8'd85, 8'd0);
		send_pixel(8'd128, 8'd128, 8'd128);
		send_pixel(8'd0, 8'd85, 8'd85);
	endtask

	task automatic send_random_pixel();
		logic [nrpc_pkg::CHAN_W-1:0] ch [3];
		int                          k;
		int                          v;
		case ($urandom_range(0, 2))
			0: begin
				for (int c = 0; c < 3; c++) ch[c] = nrpc_pkg::CHAN_W'($urandom);
			end
			1: begin
				k = $urandom_range(0, nrpc_pkg::PAL_SIZE - 1);
				for (int c = 0; c < 3; c++) begin
					v = int'(PAL_RGB[k][23 - 8 * c -: 8]) + int'($urandom_range(0, 40)) - 20;
					if (v < 0) v = 0;
					if (v > 255) v = 255;
					ch[c] = nrpc_pkg::CHAN_W'(v);
				end
			end
			default: begin
				for (int c = 0; c < 3; c++) ch[c] = EDGE_LEVELS[$urandom_range(0, 9)];
			end
		endcase
		send_pixel(ch[0], ch[1], ch[2]);
	endtask

	task automatic test_random_idling();
		idle_on = 1'b1;
		for (int i = 0; i < 700; i++) begin
			send_random_pixel();
		end
	endtask

	task automatic test_backpressure();
		idle_on   = 1'b0;
		hold_left = 80;
		for (int i = 0; i < 50; i++) begin
			send_random_pixel();
		end
	endtask

	task automatic test_full_rate();
		idle_on = 1'b0;
		for (int i = 0; i < 650; i++) begin
			send_random_pixel();
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding.", cycle_count,
				pending_colors.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		int unsigned burst;
		burst = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				result_bus.ready <= 1'b0;
				hold_left--;
			end else if (burst > 0) begin
				result_bus.ready <= 1'b0;
				burst--;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				result_bus.ready <= 1'b0;
				burst = $urandom_range(1, 6) - 1;
			end else begin
				result_bus.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		nearest_t want;
		if (arst_n && result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
			if (pending_colors.size() == 0) begin
				report_mismatch($sformatf("unexpected result beat idx=%0d dist=%0d",
					result_bus.palette_index, result_bus.min_dist_sq));
			end else begin
				want = pending_colors.pop_front();
				results_checked++;
				if (result_bus.palette_index !== want.idx)
					report_mismatch($sformatf("palette_index got %0d want %0d",
						result_bus.palette_index, want.idx));
				if (result_bus.min_dist_sq !== want.dist_sq)
					report_mismatch($sformatf("min_dist_sq got %0d want %0d",
						result_bus.min_dist_sq, want.dist_sq));
			end
		end
	end

	initial begin
		error_count      = 0;
		pixels_sent      = 0;
		results_checked  = 0;
		cycle_count      = 0;
		idle_on          = 1'b0;
		hold_left        = 0;
		arst_n           = 1'b0;
		pixel_bus.valid  = 1'b0;
		pixel_bus.red    = '0;
		pixel_bus.green  = '0;
		pixel_bus.blue   = '0;
		result_bus.ready = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corners();
		test_random_idling();
		test_backpressure();
		test_full_rate();

		pixel_bus.valid <= 1'b0;
		while (pending_colors.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (pending_colors.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_colors.size()));

		$display("Sent %0d pixels and checked %0d results: corners, palette entries, ties,",
			pixels_sent, results_checked);
		$display("random pixels with idling, a long output stall, and full-rate streaming.");
		if (error_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
